// ===== rtl/core/bcd_pkg.sv =====
// Shared types, constants and the FNV-1a step for the buffer change detector.
`default_nettype none

package bcd_pkg;

    localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_MODE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LENGTH = 8'd1;

    // Result queue sizing
    localparam int unsigned RES_FIFO_DEPTH = 4;
    localparam int unsigned RES_PTR_W      = 2;
    localparam int unsigned RES_CNT_W      = 3;

    // Stream payload widths
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 72;

    typedef struct packed {
        logic        changed;
        logic [63:0] buffer_hash;
    } t_result;

    // One FNV-1a round: xor the byte in, multiply by 0x100000001b3 mod 2^64.
    // The prime is 2^40 + 0x1b3, and 0x1b3 = 256 + 128 + 32 + 16 + 2 + 1.
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bcd_result_fifo.sv =====
// Small result queue between the compare stage and the output stream.
`default_nettype none

module bcd_result_fifo (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_push,
    input  wire bcd_pkg::t_result              i_push_data,
    output logic                               o_valid,
    input  wire                                i_ready,
    output bcd_pkg::t_result                   o_data,
    output logic [bcd_pkg::RES_CNT_W-1:0]      o_count
);
    import bcd_pkg::*;

    t_result              r_mem [RES_FIFO_DEPTH];
    logic [RES_PTR_W-1:0] r_wr_ptr;
    logic [RES_PTR_W-1:0] r_rd_ptr;
    logic [RES_CNT_W-1:0] r_count;
    logic                 w_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + RES_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + RES_PTR_W'(1);
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + RES_CNT_W'(1);
                2'b01:   r_count <= r_count - RES_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/buffer_change_detector_top.sv =====
// Top level of the buffer change detector: FNV-1a hash and byte-copy compare.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata[7:0]  data_byte
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata[0] changed, [64:1] buffer_hash
//  cfg       in   i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// One byte per cycle sustained while the result queue has room and no sweep runs;
// the FNV-1a round on the running hash register is the loop that sets this. The
// last byte reaches m_axis through the memory read, then compare and queue.
// After reset the copy store is zeroed by a sweep over all MAX_BYTES entries; bytes
// are held off during the sweep, configuration writes are taken.
// Outside the sweep, s_axis stalls only when the four-entry result queue could overflow.
`default_nettype none

module buffer_change_detector_top #(
    parameter int unsigned MAX_BYTES = 256
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // data_byte [7:0]
    input  wire  [bcd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // changed [0], buffer_hash [64:1], zero [71:65]
    output logic [bcd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [bcd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [bcd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import bcd_pkg::*;

    // Address width of the copy store and width used for length compares
    localparam int unsigned AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int unsigned CW = (AW + 1 > CFG_DATA_W) ? AW + 1 : CFG_DATA_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BYTES - 1);
    localparam logic [CW-1:0] MAX_LEN   = CW'(MAX_BYTES);

    // Configuration registers
    logic                  r_mode;
    logic [CFG_DATA_W-1:0] r_len;

    // Byte-accept stage state
    logic [63:0]   r_hash;
    logic [63:0]   n_hash;
    logic [AW-1:0] r_pos;
    logic [AW-1:0] n_pos;

    // Clearing sweep of the copy store
    logic          r_clr_active;
    logic [AW-1:0] r_clr_addr;

    // Compare stage
    logic          r_s1_valid;
    logic          r_s1_last;
    logic          r_s1_copy;
    logic [7:0]    r_s1_byte;
    logic [63:0]   r_s1_hash;
    logic [AW-1:0] r_s1_addr;
    logic          r_fwd_hit;
    logic [7:0]    r_fwd_byte;
    logic          r_mismatch;
    logic          n_mismatch;
    logic [63:0]   r_stored_hash;

    // Copy store
    logic [7:0]    r_copy_mem [MAX_BYTES];
    logic [7:0]    r_rd_data;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [7:0]    w_wr_data;

    logic                 w_accept;
    logic                 w_last;
    logic [CW-1:0]        w_eff_len;
    logic [63:0]          w_hash_step;
    logic [7:0]           w_old_byte;
    logic                 w_mis_total;
    logic                 w_push;
    t_result              w_result;
    t_result              w_out;
    logic [RES_CNT_W-1:0] w_res_count;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_len  <= CFG_DATA_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COMPARE_MODE:  r_mode <= i_cfg_data[0];
                CFG_BUFFER_LENGTH: r_len  <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // ---------------- byte accept ----------------
    // Hold bytes during the clearing sweep and whenever the result queue
    // could not take every result already committed plus this one.
    assign s_axis_tready = !r_clr_active &&
                           ((w_res_count + RES_CNT_W'(w_push)) < RES_CNT_W'(RES_FIFO_DEPTH));
    assign w_accept = s_axis_tvalid && s_axis_tready;

    // Clamp length: zero counts as one, above MAX_BYTES counts as MAX_BYTES.
    always_comb begin
        if (r_len == '0) begin
            w_eff_len = CW'(1);
        end else if (CW'(r_len) > MAX_LEN) begin
            w_eff_len = MAX_LEN;
        end else begin
            w_eff_len = CW'(r_len);
        end
    end

    assign w_last      = (CW'(r_pos) + CW'(1)) >= w_eff_len;
    assign w_hash_step = fnv_step(r_hash, s_axis_tdata);

    always_comb begin
        n_hash = r_hash;
        n_pos  = r_pos;
        if (w_accept) begin
            // Restart the hash and position after the last byte of a buffer
            n_hash = w_last ? FNV_BASIS : w_hash_step;
            n_pos  = w_last ? '0 : r_pos + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= FNV_BASIS;
            r_pos  <= '0;
        end else begin
            r_hash <= n_hash;
            r_pos  <= n_pos;
        end
    end

    // Advance the pipeline; a byte in copy mode written back at the same
    // address that is read now is forwarded, since the read sees old data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            r_fwd_hit  <= w_accept && r_s1_valid && r_s1_copy && (r_s1_addr == r_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_last  <= w_last;
            r_s1_copy  <= r_mode;
            r_s1_byte  <= s_axis_tdata;
            r_s1_hash  <= w_hash_step;
            r_s1_addr  <= r_pos;
            r_fwd_byte <= r_s1_byte;
        end
    end

    // ---------------- copy store ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    assign w_wr_en   = r_clr_active || (r_s1_valid && r_s1_copy);
    assign w_wr_addr = r_clr_active ? r_clr_addr : r_s1_addr;
    assign w_wr_data = r_clr_active ? 8'd0 : r_s1_byte;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_copy_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_data <= r_copy_mem[r_pos];
        end
    end

    // ---------------- compare ----------------
    assign w_old_byte  = r_fwd_hit ? r_fwd_byte : r_rd_data;
    assign w_mis_total = r_mismatch || (r_s1_copy && (w_old_byte != r_s1_byte));
    assign w_push      = r_s1_valid && r_s1_last;

    // The mode of the last byte decides how the changed flag is formed
    assign w_result.changed     = r_s1_copy ? w_mis_total : (r_s1_hash != r_stored_hash);
    assign w_result.buffer_hash = r_s1_hash;

    always_comb begin
        n_mismatch = r_mismatch;
        if (r_s1_valid) begin
            n_mismatch = r_s1_last ? 1'b0 : w_mis_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mismatch    <= 1'b0;
            r_stored_hash <= '0;
        end else begin
            r_mismatch <= n_mismatch;
            if (w_push && !r_s1_copy) begin
                r_stored_hash <= r_s1_hash;
            end
        end
    end

    // ---------------- result queue ----------------
    bcd_result_fifo u_result_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_result),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (w_out),
        .o_count     (w_res_count)
    );

    assign m_axis_tdata = {7'd0, w_out.buffer_hash, w_out.changed};

`ifndef ASSERT_OFF
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_res_count != RES_CNT_W'(RES_FIFO_DEPTH)))
        else $error("result pushed into a full queue");

    a_pos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |=> (r_pos == '0 && r_hash == FNV_BASIS))
        else $error("buffer state not restarted after last byte");

    a_sweep_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_active) |-> ($past(r_clr_addr) == LAST_ADDR))
        else $error("clearing sweep ended early");

    a_fwd_same_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> (r_s1_valid && $past(r_s1_copy)))
        else $error("forward taken without a copy-mode write");
`endif

endmodule

`default_nettype wire
